/* rtl/core/ucep_pkg.sv */
// Shared types and constants for the USB control endpoint handler.
package ucep_pkg;

  localparam logic [1:0] OP_BUS_RESET = 2'd0;
  localparam logic [1:0] OP_SETUP     = 2'd1;
  localparam logic [1:0] OP_IN_DONE   = 2'd2;
  localparam logic [1:0] OP_OUT_DONE  = 2'd3;

  localparam logic [1:0] EP_DISABLED = 2'd0;
  localparam logic [1:0] EP_STALL    = 2'd1;
  localparam logic [1:0] EP_NAK      = 2'd2;
  localparam logic [1:0] EP_VALID    = 2'd3;

  localparam logic [1:0] DS_UNATTACHED = 2'd0;
  localparam logic [1:0] DS_DEFAULT    = 2'd1;
  localparam logic [1:0] DS_ADDRESS    = 2'd2;
  localparam logic [1:0] DS_CONFIGURED = 2'd3;

  localparam logic [3:0] SRC_NONE   = 4'd0;
  localparam logic [3:0] SRC_ZLP    = 4'd1;
  localparam logic [3:0] SRC_DEVICE = 4'd2;
  localparam logic [3:0] SRC_CONFIG = 4'd3;
  localparam logic [3:0] SRC_LANGID = 4'd4;
  localparam logic [3:0] SRC_MANUF  = 4'd5;
  localparam logic [3:0] SRC_PROD   = 4'd6;
  localparam logic [3:0] SRC_SERIAL = 4'd7;
  localparam logic [3:0] SRC_INLINE = 4'd8;

  localparam logic [15:0] RQ_SET_ADDRESS    = 16'h0500;
  localparam logic [15:0] RQ_SET_CONFIG     = 16'h0900;
  localparam logic [15:0] RQ_SET_INTERFACE  = 16'h0B01;
  localparam logic [15:0] RQ_SET_CTRL_LINE  = 16'h2221;
  localparam logic [15:0] RQ_CLEAR_FEAT_EP  = 16'h0102;
  localparam logic [15:0] RQ_SET_FEAT_EP    = 16'h0302;
  localparam logic [15:0] RQ_GET_DESC       = 16'h0680;
  localparam logic [15:0] RQ_GET_STAT_DEV   = 16'h0080;
  localparam logic [15:0] RQ_GET_STAT_IF    = 16'h0081;
  localparam logic [15:0] RQ_GET_STAT_EP    = 16'h0082;
  localparam logic [15:0] RQ_GET_CONFIG     = 16'h0880;
  localparam logic [15:0] RQ_GET_INTERFACE  = 16'h0A81;
  localparam logic [15:0] RQ_GET_LINE_CODE  = 16'h21A1;
  localparam logic [15:0] RQ_SET_LINE_CODE  = 16'h2021;

  localparam logic [55:0] LINE_CODING_RESET = 56'h0800000001C200;

  localparam logic CFG_MANUF = 1'b0;
  localparam logic CFG_PROD  = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] request_type_code;
    logic [15:0] request_value;
    logic [15:0] request_index;
    logic [15:0] request_length;
    logic [6:0]  rx_byte_count;
    logic [55:0] out_payload;
  } ev_t;

  typedef struct packed {
    logic [1:0]  ep0_tx_status;
    logic [1:0]  ep0_rx_status;
    logic [1:0]  ep1_tx_status;
    logic [1:0]  ep1_rx_status;
    logic [3:0]  reply_source;
    logic [6:0]  reply_length;
    logic [55:0] reply_data;
    logic [6:0]  device_address;
    logic [1:0]  device_state;
    logic [15:0] control_lines;
    logic [1:0]  toggle_clear;
  } res_t;

  typedef struct packed {
    logic [1:0]  dev_state;
    logic [15:0] code;
    logic [15:0] value;
    logic [15:0] index;
    logic [15:0] length;
    logic        out_pending;
    logic [55:0] line_coding;
    logic [15:0] line_state;
    logic [6:0]  address;
    logic [1:0]  e0tx;
    logic [1:0]  e0rx;
    logic [1:0]  e1tx;
    logic [1:0]  e1rx;
  } st_t;

endpackage

/* rtl/core/ucep_if.sv */
// Valid/ready channel interfaces for events and results.
interface ucep_ev_if;
  import ucep_pkg::*;
  logic valid;
  logic ready;
  ev_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ucep_res_if;
  import ucep_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/ucep_step.sv */
// Next-state and reply logic for one control endpoint event.
module ucep_step import ucep_pkg::*; (
  input  ev_t        ev_i,
  input  st_t        st_i,
  input  logic [4:0] manuf_len_i,
  input  logic [4:0] prod_len_i,
  output st_t        st_o,
  output res_t       res_o
);

  st_t         s;
  logic        ok;
  logic [3:0]  src;
  logic [6:0]  dlen;
  logic [6:0]  rlen;
  logic [55:0] rdata;
  logic [1:0]  tog;
  logic        is_desc;
  logic [1:0]  sel;
  logic        sel_ok;

  always_comb begin
    s       = st_i;
    ok      = 1'b0;
    src     = SRC_NONE;
    dlen    = '0;
    rlen    = '0;
    rdata   = '0;
    tog     = '0;
    is_desc = 1'b0;
    sel     = '0;
    sel_ok  = 1'b0;
    unique case (ev_i.op)
      OP_BUS_RESET: begin
        s.e0tx = EP_STALL;
        s.e0rx = EP_STALL;
        s.e1tx = EP_DISABLED;
        s.e1rx = EP_DISABLED;
        s.address = '0;
        s.line_state = '0;
        s.out_pending = 1'b0;
        s.dev_state = DS_DEFAULT;
      end
      OP_SETUP: begin
        s.e0tx = EP_NAK;
        s.e0rx = EP_NAK;
        if (ev_i.rx_byte_count != 7'd8) begin
          s.e0tx = EP_STALL;
          s.e0rx = EP_STALL;
        end else begin
          s.code = ev_i.request_type_code;
          s.value = ev_i.request_value;
          s.index = ev_i.request_index;
          s.length = ev_i.request_length;
          s.out_pending = 1'b0;
          if (s.length != '0 && !s.code[7]) begin
            if (s.code == RQ_SET_LINE_CODE && s.length == 16'd7) begin
              s.out_pending = 1'b1;
              s.e0rx = EP_VALID;
            end else begin
              s.e0tx = EP_STALL;
              s.e0rx = EP_STALL;
            end
          end else begin
            if (s.length == '0) begin
              unique case (s.code)
                RQ_SET_ADDRESS:
                  ok = s.dev_state != DS_CONFIGURED && s.value < 16'd128 && s.index == '0;
                RQ_SET_CONFIG: begin
                  if (st_i.dev_state == DS_ADDRESS) begin
                    if (s.value == 16'd1) begin
                      s.e1rx = EP_VALID;
                      s.e1tx = EP_NAK;
                      s.dev_state = DS_CONFIGURED;
                      ok = 1'b1;
                    end else ok = s.value == '0;
                  end else if (st_i.dev_state == DS_CONFIGURED) begin
                    if (s.value == '0) begin
                      s.e1rx = EP_DISABLED;
                      s.e1tx = EP_DISABLED;
                      s.dev_state = DS_ADDRESS;
                      ok = 1'b1;
                    end else ok = s.value == 16'd1;
                  end
                end
                RQ_SET_INTERFACE: ok = s.dev_state == DS_CONFIGURED && s.index == '0;
                RQ_SET_CTRL_LINE: begin
                  s.line_state = s.value;
                  ok = 1'b1;
                end
                RQ_CLEAR_FEAT_EP, RQ_SET_FEAT_EP: begin
                  if (s.dev_state == DS_CONFIGURED && s.index[3:0] == 4'd1) begin
                    ok = 1'b1;
                    if (s.code == RQ_CLEAR_FEAT_EP) begin
                      if (s.index[7]) begin
                        s.e1tx = EP_NAK;
                        tog = 2'd2;
                      end else begin
                        s.e1rx = EP_NAK;
                        tog = 2'd1;
                      end
                    end else if (s.index[7]) s.e1tx = EP_STALL;
                    else s.e1rx = EP_STALL;
                  end
                end
                default: ok = 1'b0;
              endcase
              if (ok) src = SRC_ZLP;
            end else begin
              unique case (s.code)
                RQ_GET_DESC: begin
                  is_desc = 1'b1;
                  ok = 1'b1;
                  unique case (s.value)
                    16'h0100: begin
                      ok = s.index == '0; src = SRC_DEVICE; dlen = 7'd18;
                    end
                    16'h0200: begin
                      ok = s.index == '0; src = SRC_CONFIG; dlen = 7'd62;
                    end
                    16'h0300: begin src = SRC_LANGID; dlen = 7'd4; end
                    16'h0301: begin
                      src = SRC_MANUF; dlen = {1'b0, manuf_len_i, 1'b0} + 7'd2;
                    end
                    16'h0302: begin
                      src = SRC_PROD; dlen = {1'b0, prod_len_i, 1'b0} + 7'd2;
                    end
                    16'h0303: begin src = SRC_SERIAL; dlen = 7'd50; end
                    default: ok = 1'b0;
                  endcase
                  rlen = (s.length < {9'd0, dlen}) ? s.length[6:0] : dlen;
                end
                RQ_GET_STAT_DEV, RQ_GET_STAT_IF: begin
                  ok = s.dev_state != DS_DEFAULT && s.value == '0 && s.index == '0 &&
                       s.length == 16'd2;
                  src = SRC_INLINE; rlen = 7'd2;
                end
                RQ_GET_STAT_EP: begin
                  unique case (s.index)
                    16'h0000: begin sel = 2'd1; sel_ok = 1'b1; end
                    16'h0080: begin sel = 2'd0; sel_ok = 1'b1; end
                    16'h0001: begin sel = 2'd3; sel_ok = 1'b1; end
                    16'h0081: begin sel = 2'd2; sel_ok = 1'b1; end
                    default: sel_ok = 1'b0;
                  endcase
                  ok = s.dev_state != DS_DEFAULT && s.value == '0 && s.length == 16'd2 &&
                       sel_ok;
                  src = SRC_INLINE; rlen = 7'd2;
                  unique case (sel)
                    2'd0: rdata[0] = s.e0tx == EP_STALL;
                    2'd1: rdata[0] = s.e0rx == EP_STALL;
                    2'd2: rdata[0] = s.e1tx == EP_STALL;
                    default: rdata[0] = s.e1rx == EP_STALL;
                  endcase
                end
                RQ_GET_CONFIG: begin
                  ok = s.dev_state != DS_DEFAULT && s.length == 16'd1;
                  src = SRC_INLINE; rlen = 7'd1;
                  rdata[0] = s.dev_state == DS_CONFIGURED;
                end
                RQ_GET_INTERFACE: begin
                  ok = s.dev_state == DS_CONFIGURED && s.length == 16'd1;
                  src = SRC_INLINE; rlen = 7'd1;
                end
                RQ_GET_LINE_CODE: begin
                  ok = s.length == 16'd7;
                  src = SRC_INLINE; rlen = 7'd7; rdata = s.line_coding;
                end
                default: ok = 1'b0;
              endcase
            end
            if (ok) s.e0tx = EP_VALID;
            else begin
              s = st_i;
              s.code = ev_i.request_type_code;
              s.value = ev_i.request_value;
              s.index = ev_i.request_index;
              s.length = ev_i.request_length;
              s.out_pending = 1'b0;
              s.e0tx = EP_STALL;
              s.e0rx = EP_STALL;
              src = SRC_NONE; rlen = '0; rdata = '0; tog = '0;
            end
          end
        end
      end
      OP_IN_DONE: begin
        s.e0tx = EP_NAK;
        if (st_i.out_pending) s.out_pending = 1'b0;
        else if (st_i.length == '0) begin
          if (st_i.code == RQ_SET_ADDRESS) begin
            s.address = st_i.value[6:0];
            s.dev_state = (st_i.value[6:0] == '0) ? DS_DEFAULT : DS_ADDRESS;
          end
        end else s.e0rx = EP_VALID;
      end
      default: begin
        s.e0rx = EP_NAK;
        if (st_i.out_pending) begin
          if (ev_i.rx_byte_count != 7'd7) begin
            s.e0tx = EP_STALL;
            s.e0rx = EP_STALL;
          end else begin
            s.line_coding = ev_i.out_payload;
            src = SRC_ZLP;
            s.e0tx = EP_VALID;
          end
        end else if (ev_i.rx_byte_count != '0) begin
          s.e0tx = EP_STALL;
          s.e0rx = EP_STALL;
        end
      end
    endcase
    if (!is_desc && src != SRC_INLINE) rlen = '0;
    if (src != SRC_INLINE) rdata = '0;
    st_o = s;
    res_o.ep0_tx_status  = s.e0tx;
    res_o.ep0_rx_status  = s.e0rx;
    res_o.ep1_tx_status  = s.e1tx;
    res_o.ep1_rx_status  = s.e1rx;
    res_o.reply_source   = src;
    res_o.reply_length   = rlen;
    res_o.reply_data     = rdata;
    res_o.device_address = s.address;
    res_o.device_state   = s.dev_state;
    res_o.control_lines  = s.line_state;
    res_o.toggle_clear   = tog;
  end

endmodule

/* rtl/core/usb_control_endpoint_handler.sv */
// Top level of the USB control endpoint handler.
//   channel  dir  payload
//   ev_i     in   op, setup words, rx_byte_count, out_payload
//   res_o    out  endpoint statuses, reply, address, state, control lines
//   cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i (string lengths)
// One event per cycle; a result appears in the output register in the cycle
// after acceptance. Input is taken whenever that register is empty or being
// emptied, so a stalled result holds the input back. Reset (rst_ni, async)
// clears device state to unattached and all endpoints to disabled.
module usb_control_endpoint_handler import ucep_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [4:0] cfg_data_i,
  ucep_ev_if.sink    ev_i,
  ucep_res_if.source res_o
);

  st_t        st_q, st_d;
  res_t       res_d, res_q;
  logic       vld_q;
  logic [4:0] manuf_q, prod_q;
  logic       take;

  assign ev_i.ready = !vld_q || res_o.ready;
  assign take = ev_i.valid && ev_i.ready;
  assign res_o.valid = vld_q;
  assign res_o.data = res_q;

  ucep_step u_step (
    .ev_i        (ev_i.data),
    .st_i        (st_q),
    .manuf_len_i (manuf_q),
    .prod_len_i  (prod_q),
    .st_o        (st_d),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{line_coding: LINE_CODING_RESET, default: '0};
      vld_q <= 1'b0;
      manuf_q <= '0;
      prod_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MANUF) manuf_q <= cfg_data_i;
        else prod_q <= cfg_data_i;
      end
      if (take) st_q <= st_d;
      if (take) vld_q <= 1'b1;
      else if (res_o.ready) vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) res_q <= res_d;
  end

endmodule

/* sim/usb_control_endpoint_handler_tb.sv */
// Self-checking testbench, USB control endpoint handler: directed and random transfers.
module usb_control_endpoint_handler_tb;
  import ucep_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS = 1450;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic [4:0] cfg_data_i;

  ucep_ev_if  ev_if ();
  ucep_res_if res_if ();

  usb_control_endpoint_handler i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ev_i       (ev_if),
    .res_o      (res_if)
  );

  ev_t  event_q[$];
  res_t reply_q[$];
  int unsigned errors = 0;
  int unsigned item_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  bit          bursty = 0;

  // endpoint model state
  logic [4:0]  manuf_len;
  logic [4:0]  prod_len;
  logic [1:0]  dstate;
  logic [15:0] req_code;
  logic [15:0] req_val;
  logic [15:0] req_idx;
  logic [15:0] req_len;
  logic        pend;
  logic [55:0] coding;
  logic [15:0] lines;
  logic [6:0]  addr;
  logic [1:0]  e0tx, e0rx, e1tx, e1rx;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  task automatic predict_reply(input ev_t e, output res_t r);
    logic        ok;
    logic [1:0]  sel;
    logic [6:0]  size;
    logic [15:0] v, ix, n;
    logic [3:0]  src;
    logic [6:0]  rlen;
    logic [55:0] rdata;
    logic [1:0]  tog;
    src = SRC_NONE; rlen = '0; rdata = '0; tog = '0; ok = 1'b1; sel = '0; size = '0;
    v = '0; ix = '0; n = '0;
    case (e.op)
      OP_BUS_RESET: begin
        e0tx = EP_STALL; e0rx = EP_STALL; e1tx = EP_DISABLED; e1rx = EP_DISABLED;
        addr = '0; lines = '0; pend = 1'b0; dstate = DS_DEFAULT;
      end
      OP_SETUP: begin
        e0tx = EP_NAK; e0rx = EP_NAK;
        if (e.rx_byte_count != 7'd8) begin
          ok = 1'b0;
        end else begin
          req_code = e.request_type_code; req_val = e.request_value;
          req_idx = e.request_index; req_len = e.request_length;
          v = req_val; ix = req_idx; n = req_len;
          pend = 1'b0;
          if (n != 0 && !req_code[7]) begin
            if (req_code == RQ_SET_LINE_CODE && n == 16'd7) begin
              pend = 1'b1; e0rx = EP_VALID;
            end else ok = 1'b0;
          end else if (n == 0) begin
            case (req_code)
              RQ_SET_ADDRESS: ok = dstate != DS_CONFIGURED && v < 16'd128 && ix == 0;
              RQ_SET_CONFIG: begin
                if (dstate == DS_ADDRESS) begin
                  if (v == 16'd1) begin
                    e1rx = EP_VALID; e1tx = EP_NAK; dstate = DS_CONFIGURED;
                  end else ok = v == 0;
                end else if (dstate == DS_CONFIGURED) begin
                  if (v == 0) begin
                    e1rx = EP_DISABLED; e1tx = EP_DISABLED; dstate = DS_ADDRESS;
                  end else ok = v == 16'd1;
                end else ok = 1'b0;
              end
              RQ_SET_INTERFACE: ok = dstate == DS_CONFIGURED && ix == 0;
              RQ_SET_CTRL_LINE: lines = v;
              RQ_CLEAR_FEAT_EP, RQ_SET_FEAT_EP: begin
                if (dstate != DS_CONFIGURED || ix[3:0] != 4'd1) ok = 1'b0;
                else if (req_code == RQ_CLEAR_FEAT_EP) begin
                  if (ix[7]) begin
                    e1tx = EP_NAK; tog = 2'd2;
                  end else begin
                    e1rx = EP_NAK; tog = 2'd1;
                  end
                end else if (ix[7]) e1tx = EP_STALL;
                else e1rx = EP_STALL;
              end
              default: ok = 1'b0;
            endcase
            if (ok) src = SRC_ZLP;
          end else begin
            case (req_code)
              RQ_GET_DESC: begin
                case (v)
                  16'h0100: begin
                    if (ix != 0) ok = 1'b0;
                    else begin src = SRC_DEVICE; size = 7'd18; end
                  end
                  16'h0200: begin
                    if (ix != 0) ok = 1'b0;
                    else begin src = SRC_CONFIG; size = 7'd62; end
                  end
                  16'h0300: begin src = SRC_LANGID; size = 7'd4; end
                  16'h0301: begin src = SRC_MANUF; size = 7'd2 + 7'(manuf_len) * 7'd2; end
                  16'h0302: begin src = SRC_PROD; size = 7'd2 + 7'(prod_len) * 7'd2; end
                  16'h0303: begin src = SRC_SERIAL; size = 7'd50; end
                  default: ok = 1'b0;
                endcase
                if (ok) rlen = (16'(size) < n) ? size : n[6:0];
              end
              RQ_GET_STAT_DEV, RQ_GET_STAT_IF: begin
                if (dstate == DS_DEFAULT || v != 0 || ix != 0 || n != 16'd2) ok = 1'b0;
                else begin
                  src = SRC_INLINE; rlen = 7'd2;
                end
              end
              RQ_GET_STAT_EP: begin
                if (dstate == DS_DEFAULT || v != 0 || n != 16'd2) ok = 1'b0;
                else begin
                  case (ix)
                    16'h0000: sel = e0rx;
                    16'h0080: sel = e0tx;
                    16'h0001: sel = e1rx;
                    16'h0081: sel = e1tx;
                    default: ok = 1'b0;
                  endcase
                  if (ok) begin
                    src = SRC_INLINE; rlen = 7'd2;
                    rdata = (sel == EP_STALL) ? 56'd1 : 56'd0;
                  end
                end
              end
              RQ_GET_CONFIG: begin
                if (dstate == DS_DEFAULT || n != 16'd1) ok = 1'b0;
                else begin
                  src = SRC_INLINE; rlen = 7'd1;
                  rdata = (dstate == DS_CONFIGURED) ? 56'd1 : 56'd0;
                end
              end
              RQ_GET_INTERFACE: begin
                if (dstate != DS_CONFIGURED || n != 16'd1) ok = 1'b0;
                else begin
                  src = SRC_INLINE; rlen = 7'd1;
                end
              end
              RQ_GET_LINE_CODE: begin
                if (n != 16'd7) ok = 1'b0;
                else begin
                  src = SRC_INLINE; rlen = 7'd7; rdata = coding;
                end
              end
              default: ok = 1'b0;
            endcase
          end
          if (ok && !pend) e0tx = EP_VALID;
        end
      end
      OP_IN_DONE: begin
        e0tx = EP_NAK;
        if (pend) pend = 1'b0;
        else if (req_len == 0) begin
          if (req_code == RQ_SET_ADDRESS) begin
            addr = req_val[6:0];
            dstate = (addr == 0) ? DS_DEFAULT : DS_ADDRESS;
          end
        end else e0rx = EP_VALID;
      end
      default: begin
        e0rx = EP_NAK;
        if (pend) begin
          if (e.rx_byte_count != 7'd7) ok = 1'b0;
          else begin
            coding = e.out_payload; src = SRC_ZLP; e0tx = EP_VALID;
          end
        end else if (e.rx_byte_count != 0) ok = 1'b0;
      end
    endcase
    if (!ok) begin
      e0tx = EP_STALL; e0rx = EP_STALL; src = SRC_NONE; rlen = '0; rdata = '0; tog = '0;
    end
    r.ep0_tx_status = e0tx;
    r.ep0_rx_status = e0rx;
    r.ep1_tx_status = e1tx;
    r.ep1_rx_status = e1rx;
    r.reply_source = src;
    r.reply_length = rlen;
    r.reply_data = rdata;
    r.device_address = addr;
    r.device_state = dstate;
    r.control_lines = lines;
    r.toggle_clear = tog;
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    res_t r;
    if (!rst_ni) begin
      ev_if.valid <= 1'b0;
      ev_if.data <= '0;
      send_gap <= 0;
    end else begin
      if (ev_if.valid && ev_if.ready) begin
        predict_reply(ev_if.data, r);
        reply_q.push_back(r);
      end
      if (!ev_if.valid || ev_if.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          ev_if.valid <= 1'b0;
        end else if (event_q.size() > 0) begin
          ev_if.data <= event_q.pop_front();
          ev_if.valid <= 1'b1;
          send_gap <= bursty ? 0 : $urandom_range(0, 8);
        end else begin
          ev_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_r;
    res_t act_r;
    int unsigned n;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (reply_q.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          exp_r = reply_q.pop_front();
          act_r = res_if.data;
          check_field("ep0_tx_status", 64'(exp_r.ep0_tx_status), 64'(act_r.ep0_tx_status));
          check_field("ep0_rx_status", 64'(exp_r.ep0_rx_status), 64'(act_r.ep0_rx_status));
          check_field("ep1_tx_status", 64'(exp_r.ep1_tx_status), 64'(act_r.ep1_tx_status));
          check_field("ep1_rx_status", 64'(exp_r.ep1_rx_status), 64'(act_r.ep1_rx_status));
          check_field("reply_source", 64'(exp_r.reply_source), 64'(act_r.reply_source));
          check_field("reply_length", 64'(exp_r.reply_length), 64'(act_r.reply_length));
          check_field("reply_data", 64'(exp_r.reply_data), 64'(act_r.reply_data));
          check_field("device_address", 64'(exp_r.device_address),
                      64'(act_r.device_address));
          check_field("device_state", 64'(exp_r.device_state), 64'(act_r.device_state));
          check_field("control_lines", 64'(exp_r.control_lines), 64'(act_r.control_lines));
          check_field("toggle_clear", 64'(exp_r.toggle_clear), 64'(act_r.toggle_clear));
        end
        n = bursty ? 0 : $urandom_range(0, 8);
        recv_stall <= n;
        res_if.ready <= (n == 0);
      end else if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        res_if.ready <= (recv_stall == 1);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((ev_if.valid && ev_if.ready) || (res_if.valid && res_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[usb_control_endpoint_handler] ERROR");
      $finish;
    end
  end

  function automatic ev_t make_ev(logic [1:0] op, logic [15:0] code, logic [15:0] v,
                                  logic [15:0] ix, logic [15:0] n, logic [6:0] cnt,
                                  logic [55:0] pay);
    ev_t e;
    e.op = op; e.request_type_code = code; e.request_value = v; e.request_index = ix;
    e.request_length = n; e.rx_byte_count = cnt; e.out_payload = pay;
    return e;
  endfunction

  function automatic logic [55:0] rand56();
    return 56'({$urandom(), $urandom()});
  endfunction

  function automatic ev_t noise_ev();
    return make_ev(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 7'($urandom_range(0, 64)), rand56());
  endfunction

  task automatic push_setup(logic [15:0] code, logic [15:0] v, logic [15:0] ix,
                            logic [15:0] n);
    event_q.push_back(make_ev(OP_SETUP, code, v, ix, n,
                              ($urandom_range(0, 19) == 0) ? 7'($urandom_range(0, 64)) : 7'd8,
                              rand56()));
    item_count++;
  endtask

  task automatic push_stage(logic [1:0] op, logic [6:0] cnt);
    event_q.push_back(make_ev(op, 16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), cnt, rand56()));
    item_count++;
  endtask

  function automatic logic [15:0] pick_len(logic [15:0] good);
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 80));
      default: return good;
    endcase
  endfunction

  task automatic push_transfer();
    logic [15:0] code, v, ix, n;
    case ($urandom_range(0, 11))
      0: push_stage(OP_BUS_RESET, 7'($urandom_range(0, 64)));
      1: begin
        v = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 127));
        ix = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'd0;
        push_setup(RQ_SET_ADDRESS, v, ix, 16'd0);
        push_stage(OP_IN_DONE, 7'd0);
      end
      2: begin
        push_setup(RQ_SET_CONFIG, 16'($urandom_range(0, 2)), 16'd0, 16'd0);
        push_stage(OP_IN_DONE, 7'd0);
      end
      3: begin
        case ($urandom_range(0, 6))
          0: v = 16'h0100; 1: v = 16'h0200; 2: v = 16'h0300; 3: v = 16'h0301;
          4: v = 16'h0302; 5: v = 16'h0303; default: v = 16'($urandom);
        endcase
        n = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 70));
        push_setup(RQ_GET_DESC, v, ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'd0, n);
        push_stage(OP_IN_DONE, 7'd0);
        push_stage(OP_OUT_DONE, ($urandom_range(0, 7) == 0) ? 7'($urandom_range(1, 64)) : 7'd0);
      end
      4: begin
        push_setup(RQ_SET_LINE_CODE, 16'($urandom), 16'($urandom), pick_len(16'd7));
        push_stage(OP_OUT_DONE, ($urandom_range(0, 5) == 0) ? 7'($urandom_range(0, 64)) : 7'd7);
        push_stage(OP_IN_DONE, 7'd0);
      end
      5: begin
        push_setup(RQ_GET_LINE_CODE, 16'($urandom), 16'($urandom), pick_len(16'd7));
        push_stage(OP_IN_DONE, 7'd0);
        push_stage(OP_OUT_DONE, 7'd0);
      end
      6: begin
        case ($urandom_range(0, 2))
          0: code = RQ_GET_STAT_DEV; 1: code = RQ_GET_STAT_IF; default: code = RQ_GET_STAT_EP;
        endcase
        case ($urandom_range(0, 4))
          0: ix = 16'h0000; 1: ix = 16'h0080; 2: ix = 16'h0001; 3: ix = 16'h0081;
          default: ix = 16'($urandom);
        endcase
        v = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'd0;
        push_setup(code, v, ix, pick_len(16'd2));
        push_stage(OP_IN_DONE, 7'd0);
        push_stage(OP_OUT_DONE, 7'd0);
      end
      7: begin
        code = $urandom_range(0, 1) ? RQ_CLEAR_FEAT_EP : RQ_SET_FEAT_EP;
        if ($urandom_range(0, 3) == 0) ix = 16'($urandom);
        else ix = $urandom_range(0, 1) ? 16'h0081 : 16'h0001;
        push_setup(code, 16'd0, ix, 16'd0);
        push_stage(OP_IN_DONE, 7'd0);
      end
      8: begin
        case ($urandom_range(0, 3))
          0: code = RQ_GET_CONFIG; 1: code = RQ_GET_INTERFACE;
          2: code = RQ_SET_INTERFACE; default: code = RQ_SET_CTRL_LINE;
        endcase
        n = (code == RQ_SET_INTERFACE || code == RQ_SET_CTRL_LINE) ? 16'd0 : 16'd1;
        push_setup(code, 16'($urandom), ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd0,
                   ($urandom_range(0, 5) == 0) ? 16'($urandom) : n);
        push_stage(OP_IN_DONE, 7'd0);
        if (n != 0) push_stage(OP_OUT_DONE, 7'd0);
      end
      9: begin
        push_setup(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        push_stage(OP_IN_DONE, 7'd0);
      end
      default: begin
        event_q.push_back(noise_ev());
        item_count++;
      end
    endcase
  endtask

  task automatic enumerate();
    push_stage(OP_BUS_RESET, 7'd0);
    push_setup(RQ_SET_ADDRESS, 16'($urandom_range(1, 127)), 16'd0, 16'd0);
    push_stage(OP_IN_DONE, 7'd0);
    push_setup(RQ_SET_CONFIG, 16'd1, 16'd0, 16'd0);
    push_stage(OP_IN_DONE, 7'd0);
  endtask

  task automatic write_lengths(logic [4:0] m, logic [4:0] p);
    wait (event_q.size() == 0 && !ev_if.valid && reply_q.size() == 0);
    repeat (3) @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= CFG_MANUF; cfg_data_i <= m;
    manuf_len = m;
    @(posedge clk_i);
    cfg_idx_i <= CFG_PROD; cfg_data_i <= p;
    prod_len = p;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    manuf_len = '0; prod_len = '0; dstate = DS_UNATTACHED;
    req_code = '0; req_val = '0; req_idx = '0; req_len = '0; pend = 1'b0;
    coding = LINE_CODING_RESET; lines = '0; addr = '0;
    e0tx = EP_DISABLED; e0rx = EP_DISABLED; e1tx = EP_DISABLED; e1rx = EP_DISABLED;
    cfg_we_i = 1'b0; cfg_idx_i = CFG_MANUF; cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_lengths(5'd0, 5'd0);
    // directed: extremes, most requests, refusals and the special cases
    event_q.push_back(make_ev(OP_SETUP, '1, '1, '1, '1, 7'd64, '1));
    event_q.push_back(make_ev(OP_OUT_DONE, '0, '0, '0, '0, 7'd0, '0));
    push_stage(OP_IN_DONE, 7'd0);
    push_stage(OP_BUS_RESET, 7'd0);
    event_q.push_back(make_ev(OP_SETUP, RQ_GET_DESC, 16'h0100, 16'd0, 16'd64, 7'd7, '0));
    event_q.push_back(make_ev(OP_SETUP, RQ_GET_DESC, 16'h0301, 16'd0, 16'hFFFF, 7'd8, '0));
    event_q.push_back(make_ev(OP_SETUP, RQ_SET_ADDRESS, 16'h0080, 16'd0, 16'd0, 7'd8, '0));
    push_stage(OP_IN_DONE, 7'd0);
    event_q.push_back(make_ev(OP_SETUP, RQ_SET_ADDRESS, 16'h00FF, 16'd0, 16'd0, 7'd8, '0));
    push_stage(OP_IN_DONE, 7'd0);
    event_q.push_back(make_ev(OP_SETUP, RQ_SET_CONFIG, 16'd1, 16'd0, 16'd0, 7'd8, '0));
    event_q.push_back(make_ev(OP_SETUP, RQ_CLEAR_FEAT_EP, 16'd0, 16'h0081, 16'd0, 7'd8, '0));
    event_q.push_back(make_ev(OP_SETUP, RQ_SET_FEAT_EP, 16'd0, 16'h0001, 16'd0, 7'd8, '0));
    event_q.push_back(make_ev(OP_SETUP, RQ_GET_STAT_EP, 16'd0, 16'h0001, 16'd2, 7'd8, '0));
    event_q.push_back(make_ev(OP_SETUP, RQ_SET_LINE_CODE, 16'd0, 16'd0, 16'd7, 7'd8, '0));
    event_q.push_back(make_ev(OP_OUT_DONE, '0, '0, '0, '0, 7'd6, '1));
    event_q.push_back(make_ev(OP_OUT_DONE, '0, '0, '0, '0, 7'd7, '1));
    push_stage(OP_IN_DONE, 7'd0);
    event_q.push_back(make_ev(OP_SETUP, RQ_GET_LINE_CODE, 16'd0, 16'd0, 16'd7, 7'd8, '0));
    event_q.push_back(make_ev(OP_SETUP, RQ_SET_CTRL_LINE, 16'hFFFF, 16'd0, 16'd0, 7'd8, '0));
    event_q.push_back(make_ev(OP_SETUP, RQ_GET_CONFIG, 16'd0, 16'd0, 16'd1, 7'd8, '0));
    event_q.push_back(make_ev(OP_SETUP, RQ_SET_CTRL_LINE, 16'd0, 16'd0, 16'd5, 7'd8, '0));
    event_q.push_back(make_ev(OP_OUT_DONE, '0, '0, '0, '0, 7'd3, '0));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_lengths(5'd31, 5'd31);
        1: write_lengths(5'd0, 5'd31);
        2: write_lengths(5'($urandom), 5'($urandom));
        default: write_lengths(5'd31, 5'd0);
      endcase
      bursty = (ph == 1);
      enumerate();
      while (item_count < RANDOM_ITEMS * (ph + 1) / 4) begin
        if ($urandom_range(0, 40) == 0) enumerate();
        push_transfer();
      end
    end

    wait (event_q.size() == 0 && !ev_if.valid && reply_q.size() == 0);
    repeat (8) @(posedge clk_i);
    if (errors == 0 && reply_q.size() == 0) begin
      $display("[usb_control_endpoint_handler] OK");
    end else begin
      $display("[usb_control_endpoint_handler] ERROR");
    end
    $finish;
  end

endmodule
